/* design/ald_pkg.sv */
// Shared constants, types and fixed-point sizing for the ambient light auto dimmer.
package ald_pkg;

  localparam int ADC_BITS  = 12;
  localparam int FILT_W    = ADC_BITS + 8;          // Q.8 filtered level
  localparam int SUM_W     = FILT_W + 8;            // EMA accumulation
  localparam int CNT_W     = 16;
  localparam int CEIL_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // scaling: brightness = ceil * (2*FULL + 3*F) / (5*FS*256)
  localparam int NUM_W     = FILT_W + 3;
  localparam int PROD_W    = NUM_W + CEIL_W;
  localparam int X_W       = PROD_W - 8;            // product with the 256 factor dropped
  localparam int DIV_W     = ADC_BITS + 3;
  localparam int K_SHIFT   = X_W + DIV_W;
  localparam int RECIP_W   = K_SHIFT - DIV_W + 2;
  localparam int QPROD_W   = X_W + RECIP_W;

  localparam longint ADC_FS  = (longint'(1) << ADC_BITS) - 1;
  localparam longint DIVISOR = 5 * ADC_FS;
  localparam longint RECIP_L = ((longint'(1) << K_SHIFT) + DIVISOR - 1) / DIVISOR;

  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
  localparam logic [FILT_W-1:0]  FILT_FULL = {{ADC_BITS{1'b1}}, 8'h00};
  localparam logic [FILT_W-1:0]  FILT_RST  = {1'b1, {(FILT_W-1){1'b0}}};
  localparam logic [NUM_W-1:0]   NUM_BASE  = NUM_W'({FILT_FULL, 1'b0});

  localparam logic [7:0]         ALPHA_REST = 8'd205;
  localparam logic [5:0]         ALPHA_NUM  = 6'd51;
  localparam logic [CEIL_W-1:0]  OUT_FLOOR  = 8'd16;

  localparam logic [CEIL_W-1:0]  CEIL_RST   = 8'd255;
  localparam logic [CNT_W-1:0]   SAMPLE_RST = 16'd500;
  localparam logic [CNT_W-1:0]   APPLY_RST  = 16'd3000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APPLY   = 2'd2;

  typedef struct packed {
    logic                vld;
    logic [FILT_W-1:0]   level;
    logic [CEIL_W-1:0]   ceiling;
  } ald_emit_t;

endpackage

/* design/ald_filter.sv */
// Interval counters and EMA filter state, updated as each item leaves the input register.
module ald_filter import ald_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  input  logic                item_op,
  input  logic [ADC_BITS-1:0] item_adc,
  input  logic [CEIL_W-1:0]   ceiling,
  input  logic [CNT_W-1:0]    sample_ivl,
  input  logic [CNT_W-1:0]    apply_ivl,
  input  logic                down_rdy,
  output logic                item_take,
  output ald_emit_t           emit
);

  logic [FILT_W-1:0] filt_r, filt_nxt;
  logic [CNT_W-1:0]  sample_cnt_r, sample_cnt_nxt;
  logic [CNT_W-1:0]  apply_cnt_r, apply_cnt_nxt;
  logic [CNT_W-1:0]  sample_up, apply_up;
  logic              sample_fire, apply_fire;
  logic [SUM_W-1:0]  ema_sum;
  logic [FILT_W-1:0] filt_tick;

  assign item_take = item_vld && down_rdy;

  // saturating increments
  assign sample_up   = (sample_cnt_r == '1) ? sample_cnt_r : sample_cnt_r + 1'b1;
  assign apply_up    = (apply_cnt_r == '1) ? apply_cnt_r : apply_cnt_r + 1'b1;
  assign sample_fire = sample_up >= sample_ivl;
  assign apply_fire  = apply_up >= apply_ivl;

  // F' = (F*205 + adc*51*256) >> 8; stays within full scale
  assign ema_sum   = (SUM_W'(filt_r) * SUM_W'(ALPHA_REST))
                   + (SUM_W'({item_adc, 8'h00}) * SUM_W'(ALPHA_NUM));
  assign filt_tick = sample_fire ? ema_sum[SUM_W-1:8] : filt_r;

  always_comb begin
    filt_nxt       = filt_r;
    sample_cnt_nxt = sample_cnt_r;
    apply_cnt_nxt  = apply_cnt_r;
    if (item_take) begin
      if (item_op == OP_SEED) begin
        filt_nxt = {item_adc, 8'h00};
      end else begin
        filt_nxt       = filt_tick;
        sample_cnt_nxt = sample_fire ? '0 : sample_up;
        apply_cnt_nxt  = apply_fire ? '0 : apply_up;
      end
    end
  end

  assign emit.vld     = item_take && (item_op == OP_TICK) && apply_fire;
  assign emit.level   = filt_tick;
  assign emit.ceiling = ceiling;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r       <= FILT_RST;
      sample_cnt_r <= '0;
      apply_cnt_r  <= '0;
    end else begin
      filt_r       <= filt_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      apply_cnt_r  <= apply_cnt_nxt;
    end
  end

  a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
    filt_r <= FILT_FULL) else $error("filter level above full scale");

  a_seed_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && (item_op == OP_SEED) |=> $stable(sample_cnt_r) && $stable(apply_cnt_r))
    else $error("seed item moved a counter");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit.vld |=> apply_cnt_r == '0) else $error("apply counter not cleared on emit");

endmodule

/* design/ald_scale.sv */
// Brightness scaling pipeline: ceiling product, reciprocal divide, floor, result register.
module ald_scale import ald_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ald_emit_t           emit,
  output logic                load_rdy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CEIL_W-1:0]   out_brightness,
  output logic [ADC_BITS-1:0] out_light_level
);

  logic                s2_vld_r;
  logic [FILT_W-1:0]   s2_level_r;
  logic [CEIL_W-1:0]   s2_ceil_r;
  logic                s3_vld_r;
  logic [X_W-1:0]      s3_x_r;
  logic [ADC_BITS-1:0] s3_level_r;
  logic                out_vld_r;
  logic [CEIL_W-1:0]   out_bright_r;
  logic [ADC_BITS-1:0] out_level_r;

  logic                out_adv, s3_adv;
  logic [NUM_W-1:0]    num;
  logic [PROD_W-1:0]   prod;
  logic [QPROD_W-1:0]  qprod;
  logic [CEIL_W-1:0]   quot, bright_nxt;

  assign out_adv  = !out_vld_r || out_ready;
  assign s3_adv   = !s3_vld_r || out_adv;
  assign load_rdy = !s2_vld_r || s3_adv;

  assign num  = NUM_BASE + (NUM_W'(s2_level_r) * NUM_W'(3));
  assign prod = PROD_W'(s2_ceil_r) * PROD_W'(num);

  // exact floor(x / (5*FS)) for every x of X_W bits
  assign qprod      = QPROD_W'(s3_x_r) * QPROD_W'(RECIP);
  assign quot       = qprod[K_SHIFT +: CEIL_W];
  assign bright_nxt = (quot < OUT_FLOOR) ? OUT_FLOOR : quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (load_rdy) s2_vld_r  <= emit.vld;
      if (s3_adv)   s3_vld_r  <= s2_vld_r;
      if (out_adv)  out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rdy) begin
      s2_level_r <= emit.level;
      s2_ceil_r  <= emit.ceiling;
    end
    if (s3_adv) begin
      s3_x_r     <= prod[PROD_W-1:8];
      s3_level_r <= s2_level_r[FILT_W-1:8];
    end
    if (out_adv) begin
      out_bright_r <= bright_nxt;
      out_level_r  <= s3_level_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_brightness  = out_bright_r;
  assign out_light_level = out_level_r;

  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_bright_r >= OUT_FLOOR) else $error("brightness below floor");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r && out_vld_r && !out_ready |=> s3_vld_r && out_vld_r)
    else $error("stalled item lost in scaling pipeline");

endmodule

/* design/ambient_light_auto_dimmer.sv */
// Top level of the ambient light auto dimmer: config registers, input register, filter and scaler.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_ready  | in_op, in_adc_sample
//   out     | out_valid/ out_ready | out_brightness, out_light_level
//   cfg     | cfg_we               | cfg_index, cfg_wdata
//
// One item accepted per cycle when the output is drained. Once a tick leaves
// the input register, the filter update goes into the scale stage, the ceiling
// multiply into s3_x_r and the reciprocal divide into the result register.
// Filter and counters update as an item leaves the input register, so item
// order is kept. Output stalls back up through the pipeline to in_ready.
// Reset is synchronous; config registers reset to 255 / 500 / 3000.
module ambient_light_auto_dimmer import ald_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [ADC_BITS-1:0]  in_adc_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CEIL_W-1:0]    out_brightness,
  output logic [ADC_BITS-1:0]  out_light_level,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CEIL_W-1:0]   ceil_r;
  logic [CNT_W-1:0]    sample_ivl_r, apply_ivl_r;
  logic                in_vld_r;
  logic                in_op_r;
  logic [ADC_BITS-1:0] in_adc_r;
  logic                item_take, load_rdy;
  ald_emit_t           emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r       <= CEIL_RST;
      sample_ivl_r <= SAMPLE_RST;
      apply_ivl_r  <= APPLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CEILING: ceil_r       <= cfg_wdata[CEIL_W-1:0];
        REG_SAMPLE:  sample_ivl_r <= cfg_wdata;
        REG_APPLY:   apply_ivl_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !in_vld_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op_r  <= in_op;
      in_adc_r <= in_adc_sample;
    end
  end

  ald_filter u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (in_vld_r),
    .item_op    (in_op_r),
    .item_adc   (in_adc_r),
    .ceiling    (ceil_r),
    .sample_ivl (sample_ivl_r),
    .apply_ivl  (apply_ivl_r),
    .down_rdy   (load_rdy),
    .item_take  (item_take),
    .emit       (emit)
  );

  ald_scale u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .emit            (emit),
    .load_rdy        (load_rdy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_brightness  (out_brightness),
    .out_light_level (out_light_level)
  );

  a_hold_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !item_take |=> in_vld_r && $stable(in_op_r) && $stable(in_adc_r))
    else $error("pending item lost from input register");

endmodule
